FILE: src/ffpra_pkg.sv
// Package: shared constants, mode and status codes for the page range allocator.
`default_nettype none
package ffpra_pkg;
   localparam int unsigned TableDepth = 256;
   localparam int unsigned PageShift  = 12;
   localparam logic [63:0] Limit4g    = 64'h1_0000_0000;

   typedef enum logic [2:0] {
      MODE_ALLOC_LOW  = 3'd0,
      MODE_ALLOC_ANY  = 3'd1,
      MODE_ALLOC_EXEC = 3'd2,
      MODE_FREE       = 3'd3,
      MODE_FREE_EXEC  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_IGNORED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TBL_LOW  = 2'd0,
      TBL_HIGH = 2'd1,
      TBL_EXEC = 2'd2
   } table_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          load;      // capture request fields
      logic          scan_start;// clear scan index
      logic          scan_rd;   // issue read at scan index
      logic          scan_adv;  // advance scan index
      logic          take;      // write back consumed entry
      logic          append_lo; // append low (or only) part
      logic          append_hi; // append high part of a split free
      table_sel_type sel;
   } ffpra_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     scan_end;  // scan index reached used count
      logic     fits;      // registered read entry fits
      logic     split;     // free crosses 4 GiB
      logic     below_4g;  // free base below 4 GiB
      logic     full_sel;  // selected table full
      logic     full_high; // high table full
      logic     hi_nonzero;// split high part non-empty
      logic     lo_nonzero;// low part non-empty
      mode_type mode;
      logic     ignore;
   } ffpra_sts_type;
endpackage
`default_nettype wire

FILE: src/ffpra_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface ffpra_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [63:0] address;
   logic [31:0] page_count;
   modport source (output valid, mode, address, page_count, input ready);
   modport sink   (input valid, mode, address, page_count, output ready);
endinterface

interface ffpra_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_address;
   logic [1:0]  status;
   modport source (output valid, result_address, status, input ready);
   modport sink   (input valid, result_address, status, output ready);
endinterface
`default_nettype wire

FILE: src/ffpra_datapath.sv
// Datapath: range tables, scan index, fill counts and address arithmetic.
`default_nettype none
module ffpra_datapath #(
   parameter int unsigned TABLE_DEPTH = ffpra_pkg::TableDepth
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ffpra_pkg::ffpra_cmd_type cmd,
   output      ffpra_pkg::ffpra_sts_type sts,
   input  wire logic [2:0]              mode,
   input  wire logic [63:0]             address,
   input  wire logic [31:0]             page_count,
   input  wire logic [63:0]             va_offset,
   output      logic [63:0]             phys_addr
);
   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = IW + 1;
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   logic [63:0] low_base [TABLE_DEPTH];
   logic [63:0] low_len  [TABLE_DEPTH];
   logic [63:0] high_base[TABLE_DEPTH];
   logic [63:0] high_len [TABLE_DEPTH];
   logic [63:0] exec_base[TABLE_DEPTH];
   logic [63:0] exec_len [TABLE_DEPTH];

   logic [CW-1:0] low_used_ff, high_used_ff, exec_used_ff;
   logic [CW-1:0] idx_ff;
   logic [2:0]    mode_ff;
   logic [63:0]   bytes_ff, base_ff, rd_base_ff, rd_len_ff;
   logic          cnt_zero_ff, addr_zero_ff;

   logic [CW-1:0] used_sel;
   logic [63:0]   lo_part, hi_part, end_addr;
   logic [IW-1:0] rd_idx;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= mode;
         bytes_ff     <= {20'd0, page_count, 12'd0};
         cnt_zero_ff  <= (page_count == 32'd0);
         addr_zero_ff <= (address == 64'd0);
         if (va_offset != 64'd0 && address >= va_offset) begin
            base_ff <= address - va_offset;
         end else begin
            base_ff <= address;
         end
      end
   end

   always_comb begin
      case (cmd.sel)
         ffpra_pkg::TBL_LOW:  used_sel = low_used_ff;
         ffpra_pkg::TBL_HIGH: used_sel = high_used_ff;
         default:             used_sel = exec_used_ff;
      endcase
   end

   assign rd_idx   = idx_ff[IW-1:0];
   assign end_addr = base_ff + bytes_ff;
   assign lo_part  = (end_addr > ffpra_pkg::Limit4g || end_addr < base_ff)
                     ? (ffpra_pkg::Limit4g - base_ff) : bytes_ff;
   assign hi_part  = bytes_ff - lo_part;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (cmd.scan_adv) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // registered table read; the take command later writes the consumed entry back
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         case (cmd.sel)
            ffpra_pkg::TBL_LOW: begin
               rd_base_ff <= low_base[rd_idx];
               rd_len_ff  <= low_len[rd_idx];
            end
            ffpra_pkg::TBL_HIGH: begin
               rd_base_ff <= high_base[rd_idx];
               rd_len_ff  <= high_len[rd_idx];
            end
            default: begin
               rd_base_ff <= exec_base[rd_idx];
               rd_len_ff  <= exec_len[rd_idx];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         case (cmd.sel)
            ffpra_pkg::TBL_LOW: begin
               low_base[rd_idx] <= rd_base_ff + bytes_ff;
               low_len[rd_idx]  <= rd_len_ff - bytes_ff;
            end
            ffpra_pkg::TBL_HIGH: begin
               high_base[rd_idx] <= rd_base_ff + bytes_ff;
               high_len[rd_idx]  <= rd_len_ff - bytes_ff;
            end
            default: begin
               exec_base[rd_idx] <= rd_base_ff + bytes_ff;
               exec_len[rd_idx]  <= rd_len_ff - bytes_ff;
            end
         endcase
      end else if (cmd.append_lo) begin
         case (cmd.sel)
            ffpra_pkg::TBL_LOW: begin
               low_base[low_used_ff[IW-1:0]] <= base_ff;
               low_len[low_used_ff[IW-1:0]]  <= lo_part;
            end
            ffpra_pkg::TBL_HIGH: begin
               high_base[high_used_ff[IW-1:0]] <= base_ff;
               high_len[high_used_ff[IW-1:0]]  <= bytes_ff;
            end
            default: begin
               exec_base[exec_used_ff[IW-1:0]] <= base_ff;
               exec_len[exec_used_ff[IW-1:0]]  <= bytes_ff;
            end
         endcase
      end else if (cmd.append_hi) begin
         high_base[high_used_ff[IW-1:0]] <= ffpra_pkg::Limit4g;
         high_len[high_used_ff[IW-1:0]]  <= hi_part;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_used_ff  <= '0;
         high_used_ff <= '0;
         exec_used_ff <= '0;
      end else if (cmd.append_lo) begin
         case (cmd.sel)
            ffpra_pkg::TBL_LOW:  low_used_ff  <= low_used_ff + 1'b1;
            ffpra_pkg::TBL_HIGH: high_used_ff <= high_used_ff + 1'b1;
            default:             exec_used_ff <= exec_used_ff + 1'b1;
         endcase
      end else if (cmd.append_hi) begin
         high_used_ff <= high_used_ff + 1'b1;
      end
   end

   assign phys_addr      = rd_base_ff;
   assign sts.scan_end   = (idx_ff >= used_sel);
   assign sts.fits       = (rd_len_ff >= bytes_ff);
   assign sts.below_4g   = (base_ff < ffpra_pkg::Limit4g);
   assign sts.split      = (lo_part != bytes_ff);
   assign sts.full_sel   = (used_sel >= DepthC);
   assign sts.full_high  = (high_used_ff >= DepthC);
   assign sts.hi_nonzero = (hi_part != 64'd0);
   // only the low table stores the clipped part; the others take the whole range
   assign sts.lo_nonzero = (cmd.sel == ffpra_pkg::TBL_LOW) ? (lo_part != 64'd0)
                                                           : (bytes_ff != 64'd0);
   assign sts.mode       = ffpra_pkg::mode_type'(mode_ff);
   assign sts.ignore     = (mode_ff > ffpra_pkg::MODE_FREE_EXEC) || cnt_zero_ff ||
                           ((mode_ff == ffpra_pkg::MODE_FREE ||
                             mode_ff == ffpra_pkg::MODE_FREE_EXEC) && addr_zero_ff);
endmodule
`default_nettype wire

FILE: src/ffpra_ctrl.sv
// Controller: sequences decode, first-fit scan, append and response.
`default_nettype none
module ffpra_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      ffpra_pkg::ffpra_cmd_type cmd,
   input  wire ffpra_pkg::ffpra_sts_type sts,
   output      logic                    found,
   output      ffpra_pkg::status_type   status
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_CHECK  = 8'b0000_0100,
      S_READ   = 8'b0000_1000,
      S_TEST   = 8'b0001_0000,
      S_APPLO  = 8'b0010_0000,
      S_APPHI  = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   ffpra_pkg::table_sel_type sel_ff, sel_in;
   ffpra_pkg::status_type    status_ff, status_in;
   logic                     found_ff, found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ff    <= ffpra_pkg::TBL_LOW;
         status_ff <= ffpra_pkg::ST_DONE;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      status_in = status_ff;
      found_in  = found_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            found_in       = 1'b0;
            status_in      = ffpra_pkg::ST_DONE;
            cmd.scan_start = 1'b1;
            state_in       = S_CHECK;
            if (sts.ignore) begin
               status_in = ffpra_pkg::ST_IGNORED;
               state_in  = S_RESP;
            end else begin
               case (sts.mode)
                  ffpra_pkg::MODE_ALLOC_LOW:  sel_in = ffpra_pkg::TBL_LOW;
                  ffpra_pkg::MODE_ALLOC_ANY:  sel_in = ffpra_pkg::TBL_HIGH;
                  ffpra_pkg::MODE_ALLOC_EXEC: sel_in = ffpra_pkg::TBL_EXEC;
                  ffpra_pkg::MODE_FREE_EXEC: begin
                     sel_in   = ffpra_pkg::TBL_EXEC;
                     state_in = S_APPLO;
                  end
                  default: begin
                     sel_in   = sts.below_4g ? ffpra_pkg::TBL_LOW : ffpra_pkg::TBL_HIGH;
                     state_in = S_APPLO;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (sts.scan_end) begin
               if (sts.mode == ffpra_pkg::MODE_ALLOC_ANY && sel_ff == ffpra_pkg::TBL_HIGH) begin
                  sel_in         = ffpra_pkg::TBL_LOW;
                  cmd.scan_start = 1'b1;
               end else begin
                  status_in = ffpra_pkg::ST_NO_FIT;
                  state_in  = S_RESP;
               end
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            if (sts.fits) begin
               cmd.take = 1'b1;
               found_in = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_APPLO: begin
            state_in = S_APPHI;
            if (sts.lo_nonzero) begin
               if (sts.full_sel) begin
                  status_in = ffpra_pkg::ST_FULL;
               end else begin
                  cmd.append_lo = 1'b1;
               end
            end
            if (!(sel_ff == ffpra_pkg::TBL_LOW && sts.split)) begin
               state_in = S_RESP;
            end
         end
         S_APPHI: begin
            state_in = S_RESP;
            if (sts.hi_nonzero) begin
               if (sts.full_high) begin
                  status_in = ffpra_pkg::ST_FULL;
               end else begin
                  cmd.append_hi = 1'b1;
               end
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign found  = found_ff;
   assign status = status_ff;
endmodule
`default_nettype wire

FILE: src/first_fit_page_range_allocator.sv
// Top level: first-fit page range allocator with three free-range tables.
`default_nettype none
// One request at a time. An allocation reads the selected table one entry
// at a time (issue, registered read, compare) through a single read port;
// alloc any scans the high table first and falls through to the low table
// on a miss. A free appends its range, split between the low and high tables
// when it crosses 4 GiB; an ignored request goes straight to the response.
// The next request can be taken in the cycle after the response is accepted.
// Tables come up empty after reset and need no clearing.
// csr_wr_en/csr_wr_data set va_offset; write only when idle.
module first_fit_page_range_allocator #(
   parameter int unsigned TABLE_DEPTH = ffpra_pkg::TableDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ffpra_req_if.sink        req,
   ffpra_rsp_if.source      rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data
);
   ffpra_pkg::ffpra_cmd_type cmd;
   ffpra_pkg::ffpra_sts_type sts;
   ffpra_pkg::status_type    status;
   logic                     found;
   logic [63:0]              phys_addr, va_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_offset_ff <= '0;
      end else if (csr_wr_en) begin
         va_offset_ff <= csr_wr_data;
      end
   end

   ffpra_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .cmd, .sts, .found, .status
   );

   ffpra_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .mode (req.mode), .address (req.address), .page_count (req.page_count),
      .va_offset (va_offset_ff), .phys_addr
   );

   assign rsp.result_address = found ? (phys_addr + va_offset_ff) : 64'd0;
   assign rsp.status         = status;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while response pending");
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && found |-> rsp.status == ffpra_pkg::ST_DONE)
      else $error("allocation found with bad status");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.append_lo, cmd.append_hi}))
      else $error("multiple table writes");
`endif
endmodule
`default_nettype wire
